// ----- design/bfps_pkg.sv -----
// shared types and constants for the program stepper
// no dependencies
`default_nettype none
package bfps_pkg;

    typedef enum logic [3:0] {
        ST_OK        = 4'd0,
        ST_HALTED    = 4'd1,
        ST_NEEDKEY   = 4'd2,
        ST_UNM_CLOSE = 4'd3,
        ST_UNM_OPEN  = 4'd4,
        ST_RANGE     = 4'd5,
        ST_INVALID   = 4'd6,
        ST_PROGFULL  = 4'd7,
        ST_STACKFULL = 4'd8,
        ST_NOTSTART  = 4'd9
    } status_t;

    typedef enum logic [1:0] {
        CMD_CLEAR = 2'd0,
        CMD_LOAD  = 2'd1,
        CMD_START = 2'd2,
        CMD_STEP  = 2'd3
    } cmd_t;

    typedef enum logic [3:0] {
        FSM_IDLE,
        FSM_LOAD_POP,
        FSM_LOAD_JMP,
        FSM_LOAD_LINK,
        FSM_START_TOP,
        FSM_START_WAIT,
        FSM_CLEAR_TAPE,
        FSM_STEP_FETCH,
        FSM_STEP_EXEC,
        FSM_STEP_JUMP,
        FSM_DONE
    } fsm_t;

    localparam logic [7:0] CH_OPEN  = 8'h5b;
    localparam logic [7:0] CH_CLOSE = 8'h5d;
    localparam logic [7:0] CH_PLUS  = 8'h2b;
    localparam logic [7:0] CH_MINUS = 8'h2d;
    localparam logic [7:0] CH_RIGHT = 8'h3e;
    localparam logic [7:0] CH_LEFT  = 8'h3c;
    localparam logic [7:0] CH_DOT   = 8'h2e;
    localparam logic [7:0] CH_COMMA = 8'h2c;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_LF    = 8'h0a;
    localparam logic [7:0] CH_CR    = 8'h0d;

    typedef enum logic [1:0] {
        ALU_INC,
        ALU_DEC,
        ALU_PASS
    } alu_op_t;

    function automatic logic is_sticky(input status_t s);
        return (s == ST_UNM_CLOSE) || (s == ST_UNM_OPEN) || (s == ST_RANGE) ||
               (s == ST_INVALID) || (s == ST_PROGFULL) || (s == ST_STACKFULL);
    endfunction

endpackage
`default_nettype wire

// ----- design/bf_program_stepper_unit.sv -----
// top level of the program stepper: sequencer, program, jump, stack and tape memories
// depends on bfps_pkg and bfps_alu
//
// channel | direction | ports
// s_      | in        | s_valid s_ready s_cmd s_data_byte s_key_valid
// m_      | out       | m_valid m_ready m_status m_out_valid m_out_byte m_position
//
// clear goes straight to the result; start with brackets open reads the stack top, else it
// runs the tape clearing sweep, one cell a cycle; a step does program fetch and tape read,
// then a jump table read for a taken bracket, and goes straight to the result if idle
// the single memory read port of each store sets the step latency
// reset is synchronous, active low; the tape holds no reset and is swept at start
// one word at a time: s_ready is low until the result word is taken
`default_nettype none
module bf_program_stepper_unit #(
    parameter int PROG_DEPTH  = 4096,
    parameter int TAPE_DEPTH  = 32768,
    parameter int STACK_DEPTH = 256
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [1:0]  s_cmd,
    input  wire logic [7:0]  s_data_byte,
    input  wire logic        s_key_valid,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [3:0]       m_status,
    output logic             m_out_valid,
    output logic [7:0]       m_out_byte,
    output logic [12:0]      m_position
);
    localparam int PA = (PROG_DEPTH > 1) ? $clog2(PROG_DEPTH) : 1;
    localparam int PW = $clog2(PROG_DEPTH + 1);
    localparam int TA = $clog2(TAPE_DEPTH);
    localparam int TW = $clog2(TAPE_DEPTH + 1);
    localparam int SA = $clog2(STACK_DEPTH);
    localparam int SW = $clog2(STACK_DEPTH + 1);
    localparam int AW = (PW > TW) ? PW : TW;

    logic [7:0]    prog_mem [PROG_DEPTH];
    logic [PA-1:0] jump_mem [PROG_DEPTH];
    logic [PA-1:0] stack_mem [STACK_DEPTH];
    logic [7:0]    tape_mem [TAPE_DEPTH];

    bfps_pkg::fsm_t    state_reg, state_next;
    bfps_pkg::status_t status_reg, status_next;
    logic [PW-1:0] plen_reg, plen_next;
    logic [PW-1:0] pc_reg, pc_next;
    logic [TW-1:0] dp_reg, dp_next;
    logic [SW-1:0] sc_reg, sc_next;
    logic [TW-1:0] clr_reg, clr_next;
    logic [7:0]    byte_reg, byte_next;
    logic          key_reg, key_next;
    logic          outv_reg, outv_next;
    logic [7:0]    outb_reg, outb_next;

    logic [7:0]    prog_rd;
    logic [PA-1:0] jump_rd;
    logic [PA-1:0] stack_rd;
    logic [7:0]    tape_rd;

    logic          prog_we;
    logic          jump_we;
    logic [PA-1:0] jump_wa;
    logic [PA-1:0] jump_wd;
    logic [PA-1:0] jump_ra;
    logic          stack_we;
    logic [SA-1:0] stack_ra;
    logic          tape_we;
    logic [TA-1:0] tape_wa;
    logic [7:0]    tape_wd;

    bfps_pkg::alu_op_t alu_op;
    logic [AW-1:0]     alu_a, alu_y;

    bfps_alu #(.W(AW)) u_alu (.op(alu_op), .a(alu_a), .y(alu_y));

    always_ff @(posedge aclk) begin
        if (prog_we) begin
            prog_mem[plen_reg[PA-1:0]] <= byte_reg;
        end
        prog_rd <= prog_mem[pc_reg[PA-1:0]];
    end

    always_ff @(posedge aclk) begin
        if (jump_we) begin
            jump_mem[jump_wa] <= jump_wd;
        end
        jump_rd <= jump_mem[jump_ra];
    end

    always_ff @(posedge aclk) begin
        if (stack_we) begin
            stack_mem[sc_reg[SA-1:0]] <= plen_reg[PA-1:0];
        end
        stack_rd <= stack_mem[stack_ra];
    end

    always_ff @(posedge aclk) begin
        if (tape_we) begin
            tape_mem[tape_wa] <= tape_wd;
        end
        tape_rd <= tape_mem[dp_reg[TA-1:0]];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= bfps_pkg::FSM_IDLE;
            status_reg <= bfps_pkg::ST_NOTSTART;
            plen_reg   <= '0;
            pc_reg     <= '0;
            dp_reg     <= '0;
            sc_reg     <= '0;
            outv_reg   <= 1'b0;
        end else begin
            state_reg  <= state_next;
            status_reg <= status_next;
            plen_reg   <= plen_next;
            pc_reg     <= pc_next;
            dp_reg     <= dp_next;
            sc_reg     <= sc_next;
            outv_reg   <= outv_next;
        end
        clr_reg  <= clr_next;
        byte_reg <= byte_next;
        key_reg  <= key_next;
        outb_reg <= outb_next;
    end

    always_comb begin
        state_next  = state_reg;
        status_next = status_reg;
        plen_next   = plen_reg;
        pc_next     = pc_reg;
        dp_next     = dp_reg;
        sc_next     = sc_reg;
        clr_next    = clr_reg;
        byte_next   = byte_reg;
        key_next    = key_reg;
        outv_next   = outv_reg;
        outb_next   = outb_reg;
        prog_we     = 1'b0;
        jump_we     = 1'b0;
        jump_wa     = plen_reg[PA-1:0];
        jump_wd     = stack_rd;
        jump_ra     = pc_reg[PA-1:0];
        stack_we    = 1'b0;
        stack_ra    = SA'(sc_reg - SW'(1));
        tape_we     = 1'b0;
        tape_wa     = dp_reg[TA-1:0];
        tape_wd     = 8'd0;
        alu_op      = bfps_pkg::ALU_PASS;
        alu_a       = '0;
        s_ready     = 1'b0;
        case (state_reg)
            bfps_pkg::FSM_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    byte_next = s_data_byte;
                    key_next  = s_key_valid;
                    outv_next = 1'b0;
                    outb_next = 8'd0;
                    state_next = bfps_pkg::FSM_DONE;
                    if (bfps_pkg::cmd_t'(s_cmd) == bfps_pkg::CMD_CLEAR) begin
                        sc_next = '0;
                        plen_next = '0;
                        dp_next = '0;
                        pc_next = '0;
                        status_next = bfps_pkg::ST_NOTSTART;
                    end else if (bfps_pkg::is_sticky(status_reg)) begin
                        state_next = bfps_pkg::FSM_DONE;
                    end else if (bfps_pkg::cmd_t'(s_cmd) == bfps_pkg::CMD_LOAD) begin
                        if (plen_reg >= PW'(PROG_DEPTH)) begin
                            status_next = bfps_pkg::ST_PROGFULL;
                            pc_next = plen_reg;
                        end else if (s_data_byte == bfps_pkg::CH_CLOSE) begin
                            if (sc_reg == '0) begin
                                status_next = bfps_pkg::ST_UNM_CLOSE;
                                pc_next = plen_reg;
                            end else begin
                                state_next = bfps_pkg::FSM_LOAD_POP;
                            end
                        end else if (s_data_byte == bfps_pkg::CH_OPEN &&
                                     sc_reg >= SW'(STACK_DEPTH)) begin
                            status_next = bfps_pkg::ST_STACKFULL;
                            pc_next = plen_reg;
                        end else begin
                            state_next = bfps_pkg::FSM_LOAD_JMP;
                        end
                    end else if (bfps_pkg::cmd_t'(s_cmd) == bfps_pkg::CMD_START) begin
                        if (sc_reg != '0) begin
                            state_next = bfps_pkg::FSM_START_TOP;
                        end else begin
                            clr_next = '0;
                            state_next = bfps_pkg::FSM_CLEAR_TAPE;
                        end
                    end else if (status_reg == bfps_pkg::ST_OK ||
                                 status_reg == bfps_pkg::ST_NEEDKEY) begin
                        if (pc_reg >= plen_reg) begin
                            status_next = bfps_pkg::ST_HALTED;
                        end else begin
                            state_next = bfps_pkg::FSM_STEP_FETCH;
                        end
                    end
                end
            end
            bfps_pkg::FSM_LOAD_POP: begin
                // stack read issued, data on next cycle
                state_next = bfps_pkg::FSM_LOAD_JMP;
            end
            bfps_pkg::FSM_LOAD_JMP: begin
                prog_we = 1'b1;
                if (byte_reg == bfps_pkg::CH_OPEN) begin
                    stack_we = 1'b1;
                    alu_op = bfps_pkg::ALU_INC;
                    alu_a = AW'(sc_reg);
                    sc_next = SW'(alu_y);
                end else if (byte_reg == bfps_pkg::CH_CLOSE) begin
                    // first write open -> close here, close -> open below
                    jump_we = 1'b1;
                    jump_wa = stack_rd;
                    jump_wd = plen_reg[PA-1:0];
                    sc_next = sc_reg - SW'(1);
                end
                state_next = (byte_reg == bfps_pkg::CH_CLOSE) ?
                             bfps_pkg::FSM_LOAD_LINK : bfps_pkg::FSM_DONE;
                if (byte_reg != bfps_pkg::CH_CLOSE) begin
                    plen_next = plen_reg + PW'(1);
                    pc_next = '0;
                    status_next = bfps_pkg::ST_NOTSTART;
                end
            end
            bfps_pkg::FSM_LOAD_LINK: begin
                jump_we = 1'b1;
                jump_wa = plen_reg[PA-1:0];
                jump_wd = stack_rd;
                plen_next = plen_reg + PW'(1);
                pc_next = '0;
                status_next = bfps_pkg::ST_NOTSTART;
                state_next = bfps_pkg::FSM_DONE;
            end
            bfps_pkg::FSM_STEP_JUMP: begin
                // taken bracket during run
                pc_next = PW'(jump_rd) + PW'(1);
                status_next = ((PW'(jump_rd) + PW'(1)) >= plen_reg) ?
                              bfps_pkg::ST_HALTED : bfps_pkg::ST_OK;
                state_next = bfps_pkg::FSM_DONE;
            end
            bfps_pkg::FSM_START_TOP: begin
                state_next = bfps_pkg::FSM_START_WAIT;
            end
            bfps_pkg::FSM_START_WAIT: begin
                status_next = bfps_pkg::ST_UNM_OPEN;
                pc_next = PW'(stack_rd);
                state_next = bfps_pkg::FSM_DONE;
            end
            bfps_pkg::FSM_CLEAR_TAPE: begin
                tape_we = 1'b1;
                tape_wa = clr_reg[TA-1:0];
                alu_op = bfps_pkg::ALU_INC;
                alu_a = AW'(clr_reg);
                clr_next = TW'(alu_y);
                if (clr_reg == TW'(TAPE_DEPTH - 1)) begin
                    dp_next = '0;
                    pc_next = '0;
                    status_next = (plen_reg == '0) ? bfps_pkg::ST_HALTED :
                                                     bfps_pkg::ST_OK;
                    state_next = bfps_pkg::FSM_DONE;
                end
            end
            bfps_pkg::FSM_STEP_FETCH: begin
                state_next = bfps_pkg::FSM_STEP_EXEC;
            end
            bfps_pkg::FSM_STEP_EXEC: begin
                state_next = bfps_pkg::FSM_DONE;
                status_next = bfps_pkg::ST_OK;
                alu_op = bfps_pkg::ALU_INC;
                alu_a = AW'(pc_reg);
                pc_next = PW'(alu_y);
                case (prog_rd)
                    bfps_pkg::CH_DOT: begin
                        outv_next = 1'b1;
                        outb_next = tape_rd;
                    end
                    bfps_pkg::CH_COMMA: begin
                        if (!key_reg) begin
                            status_next = bfps_pkg::ST_NEEDKEY;
                            pc_next = pc_reg;
                        end else begin
                            tape_we = 1'b1;
                            tape_wd = (byte_reg == bfps_pkg::CH_CR) ?
                                      bfps_pkg::CH_LF : byte_reg;
                        end
                    end
                    bfps_pkg::CH_PLUS: begin
                        tape_we = 1'b1;
                        tape_wd = tape_rd + 8'd1;
                    end
                    bfps_pkg::CH_MINUS: begin
                        tape_we = 1'b1;
                        tape_wd = tape_rd - 8'd1;
                    end
                    bfps_pkg::CH_RIGHT: begin
                        if (dp_reg >= TW'(TAPE_DEPTH - 1)) begin
                            status_next = bfps_pkg::ST_RANGE;
                            pc_next = pc_reg;
                        end else begin
                            dp_next = dp_reg + TW'(1);
                        end
                    end
                    bfps_pkg::CH_LEFT: begin
                        if (dp_reg == '0) begin
                            status_next = bfps_pkg::ST_RANGE;
                            pc_next = pc_reg;
                        end else begin
                            dp_next = dp_reg - TW'(1);
                        end
                    end
                    bfps_pkg::CH_OPEN: begin
                        if (tape_rd == 8'd0) begin
                            state_next = bfps_pkg::FSM_STEP_JUMP;
                            pc_next = pc_reg;
                        end
                    end
                    bfps_pkg::CH_CLOSE: begin
                        if (tape_rd != 8'd0) begin
                            state_next = bfps_pkg::FSM_STEP_JUMP;
                            pc_next = pc_reg;
                        end
                    end
                    bfps_pkg::CH_SPACE, bfps_pkg::CH_LF: begin
                        pc_next = PW'(alu_y);
                    end
                    default: begin
                        status_next = bfps_pkg::ST_INVALID;
                        pc_next = pc_reg;
                    end
                endcase
                if (state_next == bfps_pkg::FSM_DONE &&
                    status_next == bfps_pkg::ST_OK && pc_next >= plen_reg) begin
                    status_next = bfps_pkg::ST_HALTED;
                end
            end
            bfps_pkg::FSM_DONE: begin
                if (m_ready) begin
                    state_next = bfps_pkg::FSM_IDLE;
                end
            end
            default: begin
                state_next = bfps_pkg::FSM_IDLE;
            end
        endcase
    end

    assign m_valid     = (state_reg == bfps_pkg::FSM_DONE);
    assign m_status    = status_reg;
    assign m_out_valid = outv_reg;
    assign m_out_byte  = outb_reg;
    assign m_position  = 13'(pc_reg);

`ifndef SYNTHESIS
    a_ready_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> !m_valid)
        else $error("ready while result pending");
    a_done_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status) && $stable(m_position))
        else $error("result changed while stalled");
    a_stack_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        sc_reg <= SW'(STACK_DEPTH))
        else $error("stack count overflow");
    a_plen_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        plen_reg <= PW'(PROG_DEPTH))
        else $error("program length overflow");
`endif

endmodule
`default_nettype wire

// ----- design/bfps_alu.sv -----
// shared incrementer / decrementer used for the program counter, stack count and clearing counter
// depends on bfps_pkg
`default_nettype none
module bfps_alu #(
    parameter int W = 16
) (
    input  wire bfps_pkg::alu_op_t op,
    input  wire logic [W-1:0]      a,
    output logic [W-1:0]           y
);
    always_comb begin
        case (op)
            bfps_pkg::ALU_INC: y = a + W'(1);
            bfps_pkg::ALU_DEC: y = a - W'(1);
            default:           y = a;
        endcase
    end
endmodule
`default_nettype wire

// ----- dv/bf_program_stepper_unit_tb.sv -----
// self-checking testbench for bf_program_stepper_unit: directed table, stack overflow, then random programs
// depends on bfps_pkg and the design files; predicts untyped result words in its own model
`timescale 1ns / 100ps
module bf_program_stepper_unit_tb;

    typedef struct {
        bfps_pkg::status_t st;
        logic        ov;
        logic [7:0]  ob;
        logic [12:0] pos;
    } step_result_t;

    typedef struct {
        bfps_pkg::cmd_t    cmd;
        logic [7:0]  data;
        logic        key;
        bit          typed;
        bfps_pkg::status_t st;
        logic        ov;
        logic [7:0]  ob;
        logic [12:0] pos;
    } stim_row_t;

    localparam int PDEPTH = 4096;
    localparam int TDEPTH = 32768;
    localparam int SDEPTH = 256;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [1:0]  s_cmd;
    logic [7:0]  s_data_byte;
    logic        s_key_valid;
    logic        m_valid;
    logic        m_ready;
    logic [3:0]  m_status;
    logic        m_out_valid;
    logic [7:0]  m_out_byte;
    logic [12:0] m_position;

    logic [7:0]  prog_mem [PDEPTH];
    logic [11:0] jump_mem [PDEPTH];
    logic [11:0] open_mem [SDEPTH];
    logic [7:0]  tape_mem [TDEPTH];
    int          open_cnt;
    int          prog_len;
    int          dptr;
    int          pcnt;
    bfps_pkg::status_t run_st;

    step_result_t pending_results[$];
    int  fail_cnt;
    bit  idle_en;
    int  item_cnt;

    bf_program_stepper_unit uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_cmd(s_cmd),
        .s_data_byte(s_data_byte), .s_key_valid(s_key_valid),
        .m_valid(m_valid), .m_ready(m_ready), .m_status(m_status),
        .m_out_valid(m_out_valid), .m_out_byte(m_out_byte), .m_position(m_position)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #100_000_000;
        $display("bf_program_stepper_unit test failed");
        $finish;
    end

    task automatic stepper_predict(input bfps_pkg::cmd_t c, input logic [7:0] b,
                                   input logic k, output step_result_t r);
        int pc;
        logic [7:0] tape_val;
        bit err;
        r.ov = 1'b0;
        r.ob = 8'd0;
        err = 1'b0;
        if (c == bfps_pkg::CMD_CLEAR) begin
            open_cnt = 0;
            prog_len = 0;
            dptr = 0;
            pcnt = 0;
            run_st = bfps_pkg::ST_NOTSTART;
        end else if (!bfps_pkg::is_sticky(run_st)) begin
            if (c == bfps_pkg::CMD_LOAD) begin
                if (prog_len >= PDEPTH) begin
                    run_st = bfps_pkg::ST_PROGFULL;
                    pcnt = prog_len;
                end else if (b == bfps_pkg::CH_OPEN && open_cnt >= SDEPTH) begin
                    run_st = bfps_pkg::ST_STACKFULL;
                    pcnt = prog_len;
                end else if (b == bfps_pkg::CH_CLOSE && open_cnt == 0) begin
                    run_st = bfps_pkg::ST_UNM_CLOSE;
                    pcnt = prog_len;
                end else begin
                    if (b == bfps_pkg::CH_OPEN) begin
                        open_mem[open_cnt] = prog_len[11:0];
                        open_cnt++;
                    end else if (b == bfps_pkg::CH_CLOSE) begin
                        open_cnt--;
                        jump_mem[open_mem[open_cnt]] = prog_len[11:0];
                        jump_mem[prog_len] = open_mem[open_cnt];
                    end
                    prog_mem[prog_len] = b;
                    prog_len++;
                    pcnt = 0;
                    run_st = bfps_pkg::ST_NOTSTART;
                end
            end else if (c == bfps_pkg::CMD_START) begin
                if (open_cnt != 0) begin
                    run_st = bfps_pkg::ST_UNM_OPEN;
                    pcnt = open_mem[open_cnt - 1];
                end else begin
                    foreach (tape_mem[i]) tape_mem[i] = 8'd0;
                    dptr = 0;
                    pcnt = 0;
                    run_st = (prog_len == 0) ? bfps_pkg::ST_HALTED : bfps_pkg::ST_OK;
                end
            end else if (run_st == bfps_pkg::ST_OK || run_st == bfps_pkg::ST_NEEDKEY) begin
                pc = pcnt;
                if (pc >= prog_len) begin
                    run_st = bfps_pkg::ST_HALTED;
                end else begin
                    tape_val = tape_mem[dptr];
                    run_st = bfps_pkg::ST_OK;
                    case (prog_mem[pc])
                        bfps_pkg::CH_DOT: begin
                            r.ov = 1'b1;
                            r.ob = tape_val;
                            pc++;
                        end
                        bfps_pkg::CH_COMMA: begin
                            if (!k) begin
                                run_st = bfps_pkg::ST_NEEDKEY;
                                err = 1'b1;
                            end else begin
                                tape_mem[dptr] = (b == bfps_pkg::CH_CR) ?
                                                 bfps_pkg::CH_LF : b;
                                pc++;
                            end
                        end
                        bfps_pkg::CH_PLUS: begin
                            tape_mem[dptr] = tape_val + 8'd1;
                            pc++;
                        end
                        bfps_pkg::CH_MINUS: begin
                            tape_mem[dptr] = tape_val - 8'd1;
                            pc++;
                        end
                        bfps_pkg::CH_RIGHT: begin
                            if (dptr + 1 >= TDEPTH) begin
                                run_st = bfps_pkg::ST_RANGE;
                                err = 1'b1;
                            end else begin
                                dptr++;
                                pc++;
                            end
                        end
                        bfps_pkg::CH_LEFT: begin
                            if (dptr == 0) begin
                                run_st = bfps_pkg::ST_RANGE;
                                err = 1'b1;
                            end else begin
                                dptr--;
                                pc++;
                            end
                        end
                        bfps_pkg::CH_OPEN:
                            pc = (tape_val == 0) ? jump_mem[pc] + 1 : pc + 1;
                        bfps_pkg::CH_CLOSE:
                            pc = (tape_val != 0) ? jump_mem[pc] + 1 : pc + 1;
                        bfps_pkg::CH_SPACE, bfps_pkg::CH_LF: pc++;
                        default: begin
                            run_st = bfps_pkg::ST_INVALID;
                            err = 1'b1;
                        end
                    endcase
                    pcnt = pc;
                    if (!err && pc >= prog_len) run_st = bfps_pkg::ST_HALTED;
                end
            end
        end
        r.st = run_st;
        r.pos = pcnt[12:0];
    endtask

    task automatic send_word(input bfps_pkg::cmd_t c, input logic [7:0] b, input logic k,
                             input bit typed, input step_result_t typed_res);
        step_result_t r;
        if (idle_en && $urandom_range(0, 5) == 0) begin
            s_valid = 1'b0;
            repeat ($urandom_range(1, 15)) @(negedge aclk);
        end
        s_valid = 1'b1;
        s_cmd = c;
        s_data_byte = b;
        s_key_valid = k;
        do @(posedge aclk); while (!s_ready);
        stepper_predict(c, b, k, r);
        pending_results.push_back(typed ? typed_res : r);
        item_cnt++;
        @(negedge aclk);
    endtask

    task automatic send_plain(input bfps_pkg::cmd_t c, input logic [7:0] b, input logic k);
        step_result_t dummy;
        send_word(c, b, k, 1'b0, dummy);
    endtask

    task automatic wait_drained();
        s_valid = 1'b0;
        while (pending_results.size() != 0) @(negedge aclk);
    endtask

    task automatic random_program(input int n_load, input int n_steps);
        int depth;
        int pick;
        logic [7:0] ops [6];
        ops = '{bfps_pkg::CH_PLUS, bfps_pkg::CH_RIGHT, bfps_pkg::CH_PLUS,
                bfps_pkg::CH_MINUS, bfps_pkg::CH_DOT, bfps_pkg::CH_COMMA};
        depth = 0;
        send_plain(bfps_pkg::CMD_CLEAR, 8'($urandom), 1'($urandom));
        for (int i = 0; i < n_load; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < 5) begin
                send_plain(bfps_pkg::CMD_LOAD, 8'($urandom), 1'($urandom));
            end else if (pick < 12) begin
                send_plain(bfps_pkg::CMD_LOAD,
                           pick[0] ? bfps_pkg::CH_SPACE : bfps_pkg::CH_LF, 1'($urandom));
            end else if (pick < 22 && depth < 4) begin
                send_plain(bfps_pkg::CMD_LOAD, bfps_pkg::CH_OPEN, 1'($urandom));
                depth++;
            end else if (pick < 34 && depth > 0) begin
                send_plain(bfps_pkg::CMD_LOAD, bfps_pkg::CH_CLOSE, 1'($urandom));
                depth--;
            end else if (pick < 37) begin
                send_plain(bfps_pkg::CMD_LOAD, bfps_pkg::CH_LEFT, 1'($urandom));
            end else begin
                send_plain(bfps_pkg::CMD_LOAD, ops[$urandom_range(0, 5)], 1'($urandom));
            end
        end
        if ($urandom_range(0, 9) != 0) begin
            while (depth > 0) begin
                send_plain(bfps_pkg::CMD_LOAD, bfps_pkg::CH_CLOSE, 1'($urandom));
                depth--;
            end
        end
        if ($urandom_range(0, 4) == 0)
            send_plain(bfps_pkg::CMD_STEP, 8'($urandom), 1'($urandom));
        wait_drained();
        send_plain(bfps_pkg::CMD_START, 8'($urandom), 1'($urandom));
        for (int i = 0; i < n_steps; i++)
            send_plain(bfps_pkg::CMD_STEP, 8'($urandom), ($urandom_range(0, 3) != 0));
    endtask

    always @(posedge aclk) begin
        step_result_t e;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                $error("result word with nothing expected");
                fail_cnt++;
            end else begin
                e = pending_results.pop_front();
                if (m_status !== e.st) begin
                    $error("status expected %0d actual %0d", e.st, m_status);
                    fail_cnt++;
                end
                if (m_out_valid !== e.ov) begin
                    $error("out_valid expected %0d actual %0d", e.ov, m_out_valid);
                    fail_cnt++;
                end
                if (m_out_byte !== e.ob) begin
                    $error("out_byte expected %0h actual %0h", e.ob, m_out_byte);
                    fail_cnt++;
                end
                if (m_position !== e.pos) begin
                    $error("position expected %0d actual %0d", e.pos, m_position);
                    fail_cnt++;
                end
            end
        end
    end

    initial begin
        m_ready = 1'b0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (idle_en && $urandom_range(0, 3) == 0) begin
                m_ready = 1'b0;
                repeat ($urandom_range(1, 15)) @(negedge aclk);
            end
            m_ready = 1'b1;
            repeat ($urandom_range(1, 20)) @(negedge aclk);
        end
    end

    initial begin
        stim_row_t rows [$];
        step_result_t tr;
        int guard;
        rows = '{
            '{bfps_pkg::CMD_STEP, 8'h00, 1'b0, 1'b1,
              bfps_pkg::ST_NOTSTART, 1'b0, 8'h00, 13'd0},
            '{bfps_pkg::CMD_START, 8'hff, 1'b1, 1'b1,
              bfps_pkg::ST_HALTED, 1'b0, 8'h00, 13'd0},
            '{bfps_pkg::CMD_STEP, 8'h00, 1'b0, 1'b1,
              bfps_pkg::ST_HALTED, 1'b0, 8'h00, 13'd0},
            '{bfps_pkg::CMD_LOAD, bfps_pkg::CH_CLOSE, 1'b0, 1'b1,
              bfps_pkg::ST_UNM_CLOSE, 1'b0, 8'h00, 13'd0},
            '{bfps_pkg::CMD_LOAD, bfps_pkg::CH_PLUS, 1'b0, 1'b1,
              bfps_pkg::ST_UNM_CLOSE, 1'b0, 8'h00, 13'd0},
            '{bfps_pkg::CMD_CLEAR, 8'h00, 1'b0, 1'b1,
              bfps_pkg::ST_NOTSTART, 1'b0, 8'h00, 13'd0},
            '{bfps_pkg::CMD_LOAD, bfps_pkg::CH_OPEN, 1'b0, 1'b0,
              bfps_pkg::ST_OK, 1'b0, 8'h00, 13'd0},
            '{bfps_pkg::CMD_START, 8'h00, 1'b0, 1'b1,
              bfps_pkg::ST_UNM_OPEN, 1'b0, 8'h00, 13'd0},
            '{bfps_pkg::CMD_CLEAR, 8'h00, 1'b0, 1'b1,
              bfps_pkg::ST_NOTSTART, 1'b0, 8'h00, 13'd0},
            '{bfps_pkg::CMD_LOAD, bfps_pkg::CH_LEFT, 1'b0, 1'b0,
              bfps_pkg::ST_OK, 1'b0, 8'h00, 13'd0},
            '{bfps_pkg::CMD_LOAD, bfps_pkg::CH_DOT, 1'b0, 1'b0,
              bfps_pkg::ST_OK, 1'b0, 8'h00, 13'd0},
            '{bfps_pkg::CMD_START, 8'h00, 1'b0, 1'b1,
              bfps_pkg::ST_OK, 1'b0, 8'h00, 13'd0},
            '{bfps_pkg::CMD_STEP, 8'h00, 1'b0, 1'b1,
              bfps_pkg::ST_RANGE, 1'b0, 8'h00, 13'd0},
            '{bfps_pkg::CMD_CLEAR, 8'h00, 1'b0, 1'b0,
              bfps_pkg::ST_OK, 1'b0, 8'h00, 13'd0},
            '{bfps_pkg::CMD_LOAD, bfps_pkg::CH_COMMA, 1'b0, 1'b0,
              bfps_pkg::ST_OK, 1'b0, 8'h00, 13'd0},
            '{bfps_pkg::CMD_LOAD, bfps_pkg::CH_DOT, 1'b0, 1'b0,
              bfps_pkg::ST_OK, 1'b0, 8'h00, 13'd0},
            '{bfps_pkg::CMD_LOAD, 8'hff, 1'b0, 1'b0,
              bfps_pkg::ST_OK, 1'b0, 8'h00, 13'd0},
            '{bfps_pkg::CMD_START, 8'h00, 1'b0, 1'b0,
              bfps_pkg::ST_OK, 1'b0, 8'h00, 13'd0},
            '{bfps_pkg::CMD_STEP, bfps_pkg::CH_CR, 1'b0, 1'b1,
              bfps_pkg::ST_NEEDKEY, 1'b0, 8'h00, 13'd0},
            '{bfps_pkg::CMD_STEP, bfps_pkg::CH_CR, 1'b1, 1'b1,
              bfps_pkg::ST_OK, 1'b0, 8'h00, 13'd1},
            '{bfps_pkg::CMD_STEP, 8'h00, 1'b0, 1'b1,
              bfps_pkg::ST_OK, 1'b1, bfps_pkg::CH_LF, 13'd2},
            '{bfps_pkg::CMD_STEP, 8'h00, 1'b0, 1'b1,
              bfps_pkg::ST_INVALID, 1'b0, 8'h00, 13'd2},
            '{bfps_pkg::CMD_STEP, 8'hff, 1'b1, 1'b1,
              bfps_pkg::ST_INVALID, 1'b0, 8'h00, 13'd2}
        };
        fail_cnt = 0;
        item_cnt = 0;
        idle_en = 1'b1;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_cmd = bfps_pkg::CMD_CLEAR;
        s_data_byte = 8'd0;
        s_key_valid = 1'b0;
        open_cnt = 0;
        prog_len = 0;
        dptr = 0;
        pcnt = 0;
        run_st = bfps_pkg::ST_NOTSTART;
        foreach (tape_mem[i]) tape_mem[i] = 8'd0;
        repeat (6) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        foreach (rows[i]) begin
            tr.st = rows[i].st;
            tr.ov = rows[i].ov;
            tr.ob = rows[i].ob;
            tr.pos = rows[i].pos;
            if (rows[i].cmd == bfps_pkg::CMD_START) wait_drained();
            send_word(rows[i].cmd, rows[i].data, rows[i].key, rows[i].typed, tr);
        end

        // stack overflow
        send_plain(bfps_pkg::CMD_CLEAR, 8'h00, 1'b0);
        repeat (SDEPTH + 1) send_plain(bfps_pkg::CMD_LOAD, bfps_pkg::CH_OPEN, 1'($urandom));
        send_plain(bfps_pkg::CMD_START, 8'h00, 1'b0);
        send_plain(bfps_pkg::CMD_CLEAR, 8'h00, 1'b0);
        send_plain(bfps_pkg::CMD_LOAD, bfps_pkg::CH_MINUS, 1'b0);
        send_plain(bfps_pkg::CMD_STEP, 8'h00, 1'b1);

        while (item_cnt < 1450) begin
            if (item_cnt > 1250) idle_en = 1'b0;
            random_program($urandom_range(4, 40), $urandom_range(20, 110));
        end

        s_valid = 1'b0;
        guard = 0;
        while (pending_results.size() != 0 && guard < 200_000) begin
            @(negedge aclk);
            guard++;
        end
        repeat (20) @(negedge aclk);
        if (fail_cnt == 0 && pending_results.size() == 0) begin
            $display("bf_program_stepper_unit test passed");
        end else begin
            $display("bf_program_stepper_unit test failed");
        end
        $finish;
    end

endmodule
